FILE: sv/ofb_pkg.sv
`timescale 1ns / 1ps

package ofb_pkg;

    localparam int COLUMN_W   = 12;
    localparam int WIDTH_W    = 13;
    localparam int PIX_W      = 8;
    localparam int NUM_W      = 21;
    localparam int DIV_STAGES = 8;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [PIX_W-1:0] DARK_RESET = 8'd50;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_WIDTH = 2'd1,
        REG_DARK  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pixel;

    // Numerator of one blended channel. With d no larger than the width the
    // sum fits in 21 bits, so the carry bit is dropped.
    function automatic logic [NUM_W-1:0] blend_num(
        input logic [PIX_W-1:0]   left,
        input logic [PIX_W-1:0]   warped,
        input logic [WIDTH_W-1:0] d,
        input logic [WIDTH_W-1:0] wd
    );
        logic [NUM_W:0] sum;
        sum = (NUM_W+1)'(left * wd) + (NUM_W+1)'(warped * d);
        return sum[NUM_W-1:0];
    endfunction

endpackage

FILE: sv/overlap_feather_blend_unit.sv
`timescale 1ns / 1ps
// Depth: eleven register stages from the input to the output register.
// Throughput: one transaction per cycle; the eight-stage divider sets the depth.
// The pipeline stalls as a whole while the output register holds an untaken result.
// Reset (synchronous, active low) clears all valid bits and loads the register
// reset values: start 0, width MAX_COLUMNS, dark threshold 50.

module overlap_feather_blend_unit #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ofb_pkg::ADDR_W-1:0]    paddr,
    input  logic [ofb_pkg::DATA_W-1:0]    pwdata,
    output logic [ofb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // Pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ofb_pkg::COLUMN_W-1:0]  i_column,
    input  logic [ofb_pkg::PIX_W-1:0]     i_left_blue,
    input  logic [ofb_pkg::PIX_W-1:0]     i_left_green,
    input  logic [ofb_pkg::PIX_W-1:0]     i_left_red,
    input  logic [ofb_pkg::PIX_W-1:0]     i_warped_blue,
    input  logic [ofb_pkg::PIX_W-1:0]     i_warped_green,
    input  logic [ofb_pkg::PIX_W-1:0]     i_warped_red,
    // Blended output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ofb_pkg::PIX_W-1:0]     o_out_blue,
    output logic [ofb_pkg::PIX_W-1:0]     o_out_green,
    output logic [ofb_pkg::PIX_W-1:0]     o_out_red
);

    localparam int Stages = ofb_pkg::DIV_STAGES;
    localparam logic [ofb_pkg::WIDTH_W-1:0] WidthReset = ofb_pkg::WIDTH_W'(MAX_COLUMNS);

    // ------------------------------------------------------------------
    // Configuration registers, read live by every stage. The user must
    // write them only while the pipeline is empty; this is not enforced.
    // ------------------------------------------------------------------
    logic [ofb_pkg::COLUMN_W-1:0] r_start;
    logic [ofb_pkg::WIDTH_W-1:0]  r_width;
    logic [ofb_pkg::PIX_W-1:0]    r_dark;
    logic                         w_wr;
    ofb_pkg::t_reg_idx            w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = ofb_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_width <= WidthReset;
            r_dark  <= ofb_pkg::DARK_RESET;
        end else if (w_wr) begin
            case (w_idx)
                ofb_pkg::REG_START: r_start <= pwdata[ofb_pkg::COLUMN_W-1:0];
                ofb_pkg::REG_WIDTH: r_width <= pwdata[ofb_pkg::WIDTH_W-1:0];
                ofb_pkg::REG_DARK:  r_dark  <= pwdata[ofb_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ofb_pkg::REG_START: prdata = ofb_pkg::DATA_W'(r_start);
            ofb_pkg::REG_WIDTH: prdata = ofb_pkg::DATA_W'(r_width);
            ofb_pkg::REG_DARK:  prdata = ofb_pkg::DATA_W'(r_dark);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. The whole pipeline moves together; it holds only when
    // the output register carries a result that the sink has not taken.
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic w_en;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    // ------------------------------------------------------------------
    // Stage 1: clamp the offset into the overlap, form the complementary
    // weight, and decide whether the warped pixel is empty fill. A zero
    // width also selects the reference pixel, so no division by zero is
    // ever used.
    // ------------------------------------------------------------------
    logic [ofb_pkg::COLUMN_W-1:0] w_diff;
    logic [ofb_pkg::WIDTH_W-1:0]  w_d_raw;
    logic [ofb_pkg::WIDTH_W-1:0]  n_d;
    logic [ofb_pkg::WIDTH_W-1:0]  n_wd;
    logic                         n_bypass;

    assign w_diff   = i_column - r_start;
    assign w_d_raw  = (i_column <= r_start) ? '0 : ofb_pkg::WIDTH_W'(w_diff);
    assign n_d      = (w_d_raw > r_width) ? r_width : w_d_raw;
    assign n_wd     = r_width - n_d;
    assign n_bypass = ((i_warped_blue < r_dark) && (i_warped_green < r_dark)
                       && (i_warped_red < r_dark)) || (r_width == '0);

    logic                        r_s1_vld;
    logic [ofb_pkg::WIDTH_W-1:0] r_s1_d;
    logic [ofb_pkg::WIDTH_W-1:0] r_s1_wd;
    logic                        r_s1_bypass;
    ofb_pkg::t_pixel             r_s1_left;
    ofb_pkg::t_pixel             r_s1_warp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d      <= n_d;
            r_s1_wd     <= n_wd;
            r_s1_bypass <= n_bypass;
            r_s1_left   <= '{blue: i_left_blue, green: i_left_green, red: i_left_red};
            r_s1_warp   <= '{blue: i_warped_blue, green: i_warped_green, red: i_warped_red};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted numerator of each channel, two 8 x 13 products
    // and one add per channel.
    // ------------------------------------------------------------------
    logic                      r_s2_vld;
    logic                      r_s2_bypass;
    ofb_pkg::t_pixel           r_s2_left;
    logic [ofb_pkg::NUM_W-1:0] r_s2_num_b;
    logic [ofb_pkg::NUM_W-1:0] r_s2_num_g;
    logic [ofb_pkg::NUM_W-1:0] r_s2_num_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_bypass <= r_s1_bypass;
            r_s2_left   <= r_s1_left;
            r_s2_num_b  <= ofb_pkg::blend_num(r_s1_left.blue, r_s1_warp.blue,
                                              r_s1_d, r_s1_wd);
            r_s2_num_g  <= ofb_pkg::blend_num(r_s1_left.green, r_s1_warp.green,
                                              r_s1_d, r_s1_wd);
            r_s2_num_r  <= ofb_pkg::blend_num(r_s1_left.red, r_s1_warp.red,
                                              r_s1_d, r_s1_wd);
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 10: one divider per channel. The numerator is a convex
    // combination of two 8-bit values times the width, so the quotient
    // always fits in eight bits.
    // ------------------------------------------------------------------
    logic [ofb_pkg::PIX_W-1:0] w_quot_b;
    logic [ofb_pkg::PIX_W-1:0] w_quot_g;
    logic [ofb_pkg::PIX_W-1:0] w_quot_r;

    ofb_divider u_div_blue (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_s2_num_b),
        .i_den  (r_width),
        .o_quot (w_quot_b)
    );

    ofb_divider u_div_green (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_s2_num_g),
        .i_den  (r_width),
        .o_quot (w_quot_g)
    );

    ofb_divider u_div_red (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_s2_num_r),
        .i_den  (r_width),
        .o_quot (w_quot_r)
    );

    // The valid bit, the bypass flag and the reference pixel travel beside
    // the divider stages so that they meet the quotient at the output.
    logic            r_dl_vld    [Stages];
    logic            r_dl_bypass [Stages];
    ofb_pkg::t_pixel r_dl_left   [Stages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Stages; i++) begin
                r_dl_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_dl_vld[0] <= r_s2_vld;
            for (int i = 1; i < Stages; i++) begin
                r_dl_vld[i] <= r_dl_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_bypass[0] <= r_s2_bypass;
            r_dl_left[0]   <= r_s2_left;
            for (int i = 1; i < Stages; i++) begin
                r_dl_bypass[i] <= r_dl_bypass[i-1];
                r_dl_left[i]   <= r_dl_left[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: output register. Empty fill and a zero width pass the
    // reference pixel unchanged; otherwise the quotients are the result.
    // ------------------------------------------------------------------
    ofb_pkg::t_pixel n_out;
    ofb_pkg::t_pixel r_out;

    assign n_out = r_dl_bypass[Stages-1] ? r_dl_left[Stages-1]
                 : ofb_pkg::t_pixel'{blue: w_quot_b, green: w_quot_g, red: w_quot_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dl_vld[Stages-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_blue  = r_out.blue;
    assign o_out_green = r_out.green;
    assign o_out_red   = r_out.red;

endmodule

FILE: sv/ofb_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per register stage, most significant
// bit first. The numerator must be below 256 times the divisor.
module ofb_divider (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ofb_pkg::NUM_W-1:0]      i_num,
    input  logic [ofb_pkg::WIDTH_W-1:0]    i_den,
    output logic [ofb_pkg::PIX_W-1:0]      o_quot
);

    logic [ofb_pkg::NUM_W-1:0] w_rem_in [ofb_pkg::DIV_STAGES];
    logic [ofb_pkg::PIX_W-1:0] w_quo_in [ofb_pkg::DIV_STAGES];
    logic [ofb_pkg::PIX_W-1:0] r_quo    [ofb_pkg::DIV_STAGES];

    assign w_rem_in[0] = i_num;
    assign w_quo_in[0] = '0;

    for (genvar j = 0; j < ofb_pkg::DIV_STAGES; j++) begin : g_stage
        localparam int Shift = ofb_pkg::DIV_STAGES - 1 - j;

        logic [ofb_pkg::NUM_W-1:0] w_div;
        logic                      w_fit;
        logic [ofb_pkg::PIX_W-1:0] n_quo;

        assign w_div = ofb_pkg::NUM_W'(i_den) << Shift;
        assign w_fit = (w_rem_in[j] >= w_div);
        assign n_quo = w_fit ? (w_quo_in[j] | (ofb_pkg::PIX_W'(1) << Shift)) : w_quo_in[j];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= n_quo;
            end
        end

        if (j < ofb_pkg::DIV_STAGES - 1) begin : g_rem
            logic [ofb_pkg::NUM_W-1:0] n_rem;
            logic [ofb_pkg::NUM_W-1:0] r_rem;

            assign n_rem = w_fit ? (w_rem_in[j] - w_div) : w_rem_in[j];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                end
            end

            assign w_rem_in[j+1] = r_rem;
            assign w_quo_in[j+1] = r_quo[j];
        end
    end

    assign o_quot = r_quo[ofb_pkg::DIV_STAGES-1];

endmodule
